### rtl/core/dqpi_pkg.sv
package dqpi_pkg;

  // Default sizing of the queue.
  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;

  // Request codes. Codes five to seven are ignored by the block.
  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_INSERT     = 3'd4
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // Per-cell move command, given anew each cycle.
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD      = 2'd1,
    CELL_FROM_PREV = 2'd2,
    CELL_FROM_NEXT = 2'd3
  } cell_cmd_t;

  // Request transaction.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [4:0]  position;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic [31:0] popped_value;
    status_t     status;
    logic [4:0]  occupancy;
    logic        is_empty;
  } out_t;

endpackage

### rtl/core/deque_with_positional_insert.sv
// Deque with positional insert, built as a row of word cells.
// The result is registered: it appears in the cycle after the request is taken.
// Throughput: one request per cycle; each operation moves the cell row by at most one step.
// busy stays low, so start is taken in any cycle outside reset.
// Reset (synchronous, active low) empties the queue; stored words are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module deque_with_positional_insert #(
  parameter int DEPTH     = dqpi_pkg::DEPTH_DEF,
  parameter int WORD_BITS = dqpi_pkg::WORD_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  dqpi_pkg::in_t   in_data,
  output logic            out_valid,
  output dqpi_pkg::out_t  out_data
);
  import dqpi_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic                 accept;
  logic [WORD_BITS-1:0] words [DEPTH];
  cell_cmd_t            cmds  [DEPTH];
  logic [WORD_BITS-1:0] load_word;
  logic [CW-1:0]        count;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Request decode, element count and result register.
  dqpi_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .CW        (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .req       (in_data),
    .words     (words),
    .cmds      (cmds),
    .load_word (load_word),
    .count     (count),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Row of cells; entry zero is the front. The row ends see zero words.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] prev_w;
    logic [WORD_BITS-1:0] next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_prev
      assign prev_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_next
      assign next_w = words[i+1];
    end
    dqpi_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmds[i]),
      .prev_word (prev_w),
      .next_word (next_w),
      .load_word (load_word),
      .word      (words[i])
    );
  end

  // The count never goes past the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CW'(DEPTH))
    else $error("element count exceeds capacity");

  // Every taken transaction yields a result in the next cycle, and only then.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("missing result after a taken transaction");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept))
    else $error("result without a taken transaction");

  // A failed request leaves the count as it was.
  a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> $stable(count))
    else $error("failed request changed the count");

  // The empty flag agrees with the count.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_empty == (count == '0)))
    else $error("empty flag disagrees with count");

endmodule

### rtl/core/dqpi_cell.sv
module dqpi_cell #(
  parameter int WORD_BITS = dqpi_pkg::WORD_BITS_DEF
) (
  input  logic                  clk,
  input  dqpi_pkg::cell_cmd_t   cmd,
  input  logic [WORD_BITS-1:0]  prev_word,
  input  logic [WORD_BITS-1:0]  next_word,
  input  logic [WORD_BITS-1:0]  load_word,
  output logic [WORD_BITS-1:0]  word
);
  import dqpi_pkg::*;

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;

  // Pick the new content: keep it, take the new word, or take a neighbor's word.
  always_comb begin
    unique case (cmd)
      CELL_HOLD:      word_nxt = word_r;
      CELL_LOAD:      word_nxt = load_word;
      CELL_FROM_PREV: word_nxt = prev_word;
      CELL_FROM_NEXT: word_nxt = next_word;
      default:        word_nxt = word_r;
    endcase
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

### rtl/core/dqpi_ctrl.sv
module dqpi_ctrl #(
  parameter int DEPTH     = dqpi_pkg::DEPTH_DEF,
  parameter int WORD_BITS = dqpi_pkg::WORD_BITS_DEF,
  parameter int CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  dqpi_pkg::in_t         req,
  input  logic [WORD_BITS-1:0]  words [DEPTH],
  output dqpi_pkg::cell_cmd_t   cmds [DEPTH],
  output logic [WORD_BITS-1:0]  load_word,
  output logic [CW-1:0]         count,
  output logic                  out_valid,
  output dqpi_pkg::out_t        out_data
);
  import dqpi_pkg::*;

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMPW = (CW > 5) ? CW : 5;

  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic                  out_valid_r;
  out_t                  out_r;
  out_t                  out_nxt;

  logic                  do_put;
  logic                  do_pop_front;
  logic                  do_pop_back;
  logic [CW-1:0]         put_at;
  status_t               status;
  logic                  full;
  logic                  empty;
  logic                  pos_bad;
  logic [CW-1:0]         count_m1;
  logic [IW-1:0]         back_idx;
  logic [WORD_BITS-1:0]  popped_word;
  logic [WORD_BITS+31:0] value_ext;
  logic [WORD_BITS+31:0] popped_ext;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pos_bad  = (CMPW'(req.position) > CMPW'(count_r));
  assign count_m1 = count_r - 1'b1;
  assign back_idx = count_m1[IW-1:0];

  // Fit the incoming word to the stored word width.
  assign value_ext = {{WORD_BITS{1'b0}}, req.value};
  assign load_word = value_ext[WORD_BITS-1:0];

  // Decode the request into a put, a pop and a status.
  always_comb begin
    do_put       = 1'b0;
    do_pop_front = 1'b0;
    do_pop_back  = 1'b0;
    put_at       = '0;
    status       = ST_OK;
    unique case (req.kind)
      KIND_PUSH_FRONT: begin
        if (full) status = ST_FULL;
        else      do_put = 1'b1;
      end
      KIND_PUSH_BACK: begin
        put_at = count_r;
        if (full) status = ST_FULL;
        else      do_put = 1'b1;
      end
      KIND_POP_FRONT: begin
        if (empty) status = ST_EMPTY;
        else       do_pop_front = 1'b1;
      end
      KIND_POP_BACK: begin
        if (empty) status = ST_EMPTY;
        else       do_pop_back = 1'b1;
      end
      KIND_INSERT: begin
        put_at = CW'(req.position);
        if (full)         status = ST_FULL;
        else if (pos_bad) status = ST_BADPOS;
        else              do_put = 1'b1;
      end
      default: ;
    endcase
  end

  // Per-cell commands: a put opens a gap by moving the tail one cell back,
  // a front pop moves each word behind the front one step forward.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cmds[i] = CELL_HOLD;
      if (accept && do_put) begin
        if (CW'(i) == put_at)
          cmds[i] = CELL_LOAD;
        else if (CW'(i) > put_at && CW'(i) <= count_r)
          cmds[i] = CELL_FROM_PREV;
      end else if (accept && do_pop_front) begin
        if (CW'(i) < count_m1)
          cmds[i] = CELL_FROM_NEXT;
      end
    end
  end

  // Next element count.
  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (do_put)
        count_nxt = count_r + 1'b1;
      else if (do_pop_front || do_pop_back)
        count_nxt = count_m1;
    end
  end

  // Word leaving the queue and the result fields.
  always_comb begin
    popped_word = '0;
    if (do_pop_front)
      popped_word = words[0];
    else if (do_pop_back)
      popped_word = words[back_idx];
    popped_ext             = {32'd0, popped_word};
    out_nxt.popped_value   = popped_ext[31:0];
    out_nxt.status         = status;
    out_nxt.occupancy      = 5'(count_nxt);
    out_nxt.is_empty       = (count_nxt == '0);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign count     = count_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### verif/dqpi_result_checker.sv
`timescale 1ns / 1ps

// Watches the request and result channels of the deque, keeps its own copy of
// the queue contents, and compares every result with the predicted one.
module dqpi_result_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  dqpi_pkg::in_t  in_data,
  input  logic           out_valid,
  input  dqpi_pkg::out_t out_data,
  output int             errors,
  output int             pending,
  output int             n_results,
  output int             n_empty_status,
  output int             n_full_status,
  output int             n_badpos_status,
  output int             peak_occupancy
);
  import dqpi_pkg::*;

  localparam int DEPTH = DEPTH_DEF;

  // Shadow copy of the queue: entry 0 is the front.
  logic [31:0] words [DEPTH];
  int unsigned fill;

  // Results predicted for accepted requests, oldest first.
  out_t expected_results [$];

  initial begin
    errors          = 0;
    n_results       = 0;
    n_empty_status  = 0;
    n_full_status   = 0;
    n_badpos_status = 0;
    peak_occupancy  = 0;
    fill            = 0;
  end

  assign pending = expected_results.size();

  // Opens a gap at index at and stores the word there.
  function automatic void open_and_store(int unsigned at, logic [31:0] word);
    for (int unsigned i = fill; i > at; i--) begin
      words[i] = words[i - 1];
    end
    words[at] = word;
    fill++;
  endfunction

  // Applies one request to the shadow queue and returns the result it gives.
  function automatic out_t apply_request(in_t req);
    out_t r;
    r = '0;
    r.status = ST_OK;
    case (req.kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (fill >= DEPTH) r.status = ST_FULL;
        else open_and_store(req.kind == KIND_PUSH_FRONT ? 0 : fill, req.value);
      end
      KIND_POP_FRONT: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_value = words[0];
          for (int unsigned i = 1; i < fill; i++) words[i - 1] = words[i];
          fill--;
        end
      end
      KIND_POP_BACK: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          fill--;
          r.popped_value = words[fill];
        end
      end
      KIND_INSERT: begin
        // The full check takes priority over the position check.
        if (fill >= DEPTH) r.status = ST_FULL;
        else if (req.position > fill) r.status = ST_BADPOS;
        else open_and_store(req.position, req.value);
      end
      default: begin
        // Unknown codes leave the contents alone.
      end
    endcase
    r.occupancy = 5'(fill);
    r.is_empty  = (fill == 0);
    return r;
  endfunction

  // Results are checked before the request of the same edge is predicted,
  // so the oldest expectation always lines up with the result on the port.
  always @(posedge clk) begin
    out_t exp_res;
    if (!rst_n) begin
      fill = 0;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        n_results++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display({"%0t: result with no request outstanding: ",
                      "popped=%h status=%0d occ=%0d empty=%0b"},
                     $realtime, out_data.popped_value, out_data.status,
                     out_data.occupancy, out_data.is_empty);
        end else begin
          exp_res = expected_results.pop_front();
          if (out_data.popped_value !== exp_res.popped_value ||
              out_data.status !== exp_res.status ||
              out_data.occupancy !== exp_res.occupancy ||
              out_data.is_empty !== exp_res.is_empty) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: mismatch: expected popped=%h status=%0d occ=%0d empty=%0b, ",
                        "got popped=%h status=%0d occ=%0d empty=%0b"},
                       $realtime, exp_res.popped_value, exp_res.status,
                       exp_res.occupancy, exp_res.is_empty,
                       out_data.popped_value, out_data.status,
                       out_data.occupancy, out_data.is_empty);
          end
        end
      end
      if (start && !busy) begin
        exp_res = apply_request(in_data);
        expected_results.push_back(exp_res);
        case (exp_res.status)
          ST_EMPTY:  n_empty_status++;
          ST_FULL:   n_full_status++;
          ST_BADPOS: n_badpos_status++;
          default: ;
        endcase
        if (int'(fill) > peak_occupancy) peak_occupancy = int'(fill);
      end
    end
  end

endmodule

### verif/tb_deque_with_positional_insert.sv
`timescale 1ns / 1ps

module tb_deque_with_positional_insert;
  import dqpi_pkg::*;

  localparam int RANDOM_REQUESTS = 1950;
  localparam int WATCHDOG_LIMIT  = 1000;
  // Request numbers of the random part that are sent without any idling.
  localparam int QUIET_FIRST     = 700;
  localparam int QUIET_LAST      = 1000;
  // Mix of requests in the random part.
  localparam int MODE_FILL       = 0;
  localparam int MODE_DRAIN      = 1;
  localparam int MODE_MIXED      = 2;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic out_valid;
  in_t  in_data;
  out_t out_data;

  int errors;
  int pending;
  int n_results;
  int n_empty_status;
  int n_full_status;
  int n_badpos_status;
  int peak_occupancy;
  int stuck_cycles;
  bit no_idle;

  deque_with_positional_insert uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  dqpi_result_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .errors         (errors),
    .pending        (pending),
    .n_results      (n_results),
    .n_empty_status (n_empty_status),
    .n_full_status  (n_full_status),
    .n_badpos_status(n_badpos_status),
    .peak_occupancy (peak_occupancy)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Ends the run when neither channel has moved a transaction for too long.
  initial stuck_cycles = 0;
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || out_valid) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog expired: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Sends one request, idling first at random; starts and ends at a falling edge.
  task automatic send(input kind_t kind, input logic [31:0] value,
                      input logic [4:0] position);
    while (!no_idle && $urandom_range(0, 99) < 26) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= '{kind: kind, value: value, position: position};
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    kind_t       kind;
    logic [31:0] value;
    logic [4:0]  position;
    int          mode;
    int          mode_left;
    int          grow_pct;
    int          pick;
    int          valid_sent;

    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    no_idle = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: empty pops, unknown code, bad positions, both ends.
    send(KIND_POP_FRONT, 32'h1234_5678, 5'd0);
    send(KIND_POP_BACK, 32'hFFFF_FFFF, 5'd31);
    send(kind_t'(3'(KIND_INSERT) + 3'd3), 32'hDEAD_BEEF, 5'd0);
    send(KIND_INSERT, 32'hAAAA_AAAA, 5'd1);
    send(KIND_INSERT, 32'h0000_0000, 5'd0);
    send(KIND_PUSH_FRONT, 32'hFFFF_FFFF, 5'd0);
    send(KIND_PUSH_BACK, 32'h8000_0000, 5'd16);
    send(KIND_INSERT, 32'h5555_5555, 5'd3);
    send(KIND_INSERT, 32'h0000_0001, 5'd2);
    send(KIND_INSERT, 32'h7FFF_FFFF, 5'd31);
    send(KIND_POP_FRONT, 32'h0, 5'd0);
    send(KIND_POP_BACK, 32'h0, 5'd0);
    send(kind_t'(3'(KIND_INSERT) + 3'd1), 32'h0, 5'd16);

    // Fill to the limit with three entries already stored, then hit it.
    for (int j = 0; j < 13; j++) begin
      case (j % 3)
        0: send(KIND_PUSH_FRONT, 32'h1000_0000 + j, 5'd0);
        1: send(KIND_PUSH_BACK, 32'h2000_0000 + j, 5'd0);
        default: send(KIND_INSERT, 32'h3000_0000 + j, 5'((3 + j) / 2));
      endcase
    end
    send(KIND_PUSH_BACK, 32'hCAFE_F00D, 5'd0);
    send(KIND_INSERT, 32'hCAFE_F00D, 5'd31);
    send(KIND_INSERT, 32'hCAFE_F00D, 5'd16);

    // Random part: stretches that favor growing, shrinking, or neither, so
    // the queue swings between empty and full with random contents.
    valid_sent = 0;
    mode_left  = 0;
    mode       = MODE_MIXED;
    while (valid_sent < RANDOM_REQUESTS) begin
      if (mode_left == 0) begin
        mode      = $urandom_range(MODE_FILL, MODE_MIXED);
        mode_left = $urandom_range(20, 60);
      end
      mode_left--;
      grow_pct = (mode == MODE_FILL) ? 75 : (mode == MODE_DRAIN) ? 25 : 50;
      no_idle  = (valid_sent >= QUIET_FIRST && valid_sent < QUIET_LAST);

      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        kind = kind_t'(3'(KIND_INSERT) + 3'($urandom_range(1, 3)));
      end else if (pick < grow_pct) begin
        case ($urandom_range(0, 2))
          0: kind = KIND_PUSH_FRONT;
          1: kind = KIND_PUSH_BACK;
          default: kind = KIND_INSERT;
        endcase
      end else begin
        kind = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
      end

      case ($urandom_range(0, 9))
        0: value = '0;
        1: value = '1;
        2: value = 32'h1 << $urandom_range(0, 31);
        default: value = $urandom();
      endcase
      position = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, 16)) : 5'($urandom());

      send(kind, value, position);
      if (kind <= KIND_INSERT) valid_sent++;
    end
    start <= 1'b0;

    // Let the last results come back; the watchdog bounds this wait.
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Checked %0d results; peak occupancy %0d.", n_results, peak_occupancy);
    $display("Rejections seen: %0d pops from empty, %0d requests when full, %0d bad positions.",
             n_empty_status, n_full_status, n_badpos_status);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/dqpi_pkg.sv
rtl/core/dqpi_cell.sv
rtl/core/dqpi_ctrl.sv
rtl/core/deque_with_positional_insert.sv
verif/dqpi_result_checker.sv
verif/tb_deque_with_positional_insert.sv
